// ----- hdl/ssdr_pkg.sv -----
`timescale 1ns / 1ps
package ssdr_pkg;

  localparam int unsigned SampleW  = 16;
  localparam int unsigned LenW     = 21;
  localparam int unsigned CrossW   = 52;
  localparam int unsigned EnergyW  = 51;
  localparam int unsigned ProdW    = 102;
  localparam int unsigned SegW     = 17;
  localparam int unsigned TotalW   = 33;
  localparam int unsigned TopW     = 7;
  localparam int unsigned FracW    = 24;
  localparam int unsigned LogW     = TopW + FracW;
  localparam int unsigned ScaleW   = 57;
  localparam int unsigned RatioW   = 16;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned StepW    = 6;
  localparam int unsigned OutDataW = 24;

  localparam logic [LenW-1:0]   MaxLength   = 21'h100000;
  localparam logic [SegW-1:0]   MaxSegments = 17'h10000;
  localparam logic [25:0]       DbPerOctave = 26'd50504453;
  localparam logic [StepW-1:0]  MulLast     = 6'd50;
  localparam logic [StepW-1:0]  LogLast     = 6'd23;
  localparam logic [StepW-1:0]  DivLast     = 6'd32;

  localparam logic KindSeg  = 1'b0;
  localparam logic KindMean = 1'b1;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 3'd0,
    ST_ZERO_DIST = 3'd1,
    ST_ZERO_CORR = 3'd2,
    ST_SHORT     = 3'd3,
    ST_OVERFLOW  = 3'd4
  } status_e;

  typedef struct packed {
    logic acc;
    logic set_special;
    logic mul_start;
    logic mul_step;
    logic set_full;
    logic log_load;
    logic log_sel_den;
    logic norm_step;
    logic log_mant;
    logic sqr_step;
    logic store_ln;
    logic scale;
    logic round;
    logic seg_emit;
    logic div_start;
    logic div_step;
    logic mean_emit;
  } cmd_t;

  typedef struct packed {
    logic trigger;
    logic special;
    logic den_zero;
    logic norm_msb;
    logic out_free;
    logic mean_req;
    logic mean_special;
  } stat_t;

endpackage

// ----- hdl/segmental_sdr_meter.sv -----
`timescale 1ns / 1ps
// Channel   Direction  Payload
// s_axis    in         tdata: reference_sample, estimate_sample; tlast: stream_last
// m_axis    out        tdata: ratio_db, status; tuser: result_kind; tlast: result_last
// cfg       in         cfg_data_i: segment_length
//
// An item that closes no measurement is added to the sums in the idle state. An item that
// closes one holds the input until its result is emitted; unless a special case ends it
// early, this runs the bit-serial multipliers and two normalizing and log passes of the
// shared log unit. A segment mean also holds the input while the serial divider runs.
// Reset is asynchronous and clears all sums and counters; no clearing pass.
// A result waits in the output register while the next item is taken.
module segmental_sdr_meter import ssdr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [31:0]         s_axis_tdata,  // reference_sample, estimate_sample
  input  logic                s_axis_tlast,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,  // ratio_db, status
  output logic [0:0]          m_axis_tuser,  // result_kind
  output logic                m_axis_tlast,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [LenW-1:0]     cfg_data_i
);

  logic [LenW-1:0]    seg_len_q;
  cmd_t               cmd;
  stat_t              stat;
  logic               out_kind;
  logic [RatioW-1:0]  out_ratio;
  logic [StatusW-1:0] out_status;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_len_q <= '0;
    end else if (cfg_valid_i) begin
      seg_len_q <= cfg_data_i;
    end
  end

  ssdr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ssdr_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .seg_len_i    (seg_len_q),
    .ref_i        ($signed(s_axis_tdata[15:0])),
    .est_i        ($signed(s_axis_tdata[31:16])),
    .last_i       (s_axis_tlast),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_kind_o   (out_kind),
    .out_last_o   (m_axis_tlast),
    .out_ratio_o  (out_ratio),
    .out_status_o (out_status)
  );

  assign m_axis_tdata = {5'b0, out_status, out_ratio};
  assign m_axis_tuser = out_kind;

endmodule

// ----- hdl/ssdr_dp.sv -----
`timescale 1ns / 1ps
module ssdr_dp import ssdr_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [LenW-1:0]           seg_len_i,
  input  logic signed [SampleW-1:0] ref_i,
  input  logic signed [SampleW-1:0] est_i,
  input  logic                      last_i,
  input  cmd_t                      cmd_i,
  output stat_t                     stat_o,
  input  logic                      out_ready_i,
  output logic                      out_valid_o,
  output logic                      out_kind_o,
  output logic                      out_last_o,
  output logic [RatioW-1:0]         out_ratio_o,
  output logic [StatusW-1:0]        out_status_o
);

  // accumulators
  logic signed [CrossW-1:0] cross_q;
  logic [EnergyW-1:0]       rxx_q, ryy_q;
  logic [LenW-1:0]          cnt_q, cnt_next;
  logic                     len_ovf_q, last_q, cnt_full, seg;
  logic signed [31:0]       pxy, pxx, pyy;

  // mean state
  logic [SegW-1:0]          segs_q;
  logic signed [TotalW-1:0] total_q;
  logic                     mean_ovf_q;

  // measurement result
  logic [RatioW-1:0]        res_ratio_q;
  logic [StatusW-1:0]       res_status_q;

  // serial multipliers
  logic [EnergyW-1:0]       mag_q, bn_q, bd_q, mag;
  logic [CrossW-1:0]        mag_full;
  logic [ProdW-1:0]         an_q, ad_q, den;

  // log unit
  logic [ProdW-1:0]         norm_q;
  logic [TopW-1:0]          top_q;
  logic [31:0]              m_q;
  logic [FracW-1:0]         frac_q;
  logic [63:0]              sq;
  logic [LogW-1:0]          ln_q, ld;
  logic [LogW-1:0]          dmag;
  logic                     neg_q, dneg;
  logic [ScaleW-1:0]        sc_q, rsum;
  logic [16:0]              rq;

  // divider
  logic [TotalW-1:0]        quo_q, mabs;
  logic [17:0]              rem_q, dv;
  logic [18:0]              r2;
  logic                     ge, mneg_q;
  logic [RatioW-1:0]        mean_ratio;
  logic [StatusW-1:0]       mean_status;

  // output register
  logic                     out_valid_q, out_kind_q, out_last_q, out_free;
  logic [RatioW-1:0]        out_ratio_q;
  logic [StatusW-1:0]       out_status_q;

  assign seg      = seg_len_i != '0;
  assign pxy      = 32'(ref_i) * 32'(est_i);
  assign pxx      = 32'(ref_i) * 32'(ref_i);
  assign pyy      = 32'(est_i) * 32'(est_i);
  assign cnt_full = cnt_q >= MaxLength;
  assign cnt_next = cnt_full ? cnt_q : cnt_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cross_q   <= '0;
      rxx_q     <= '0;
      ryy_q     <= '0;
      cnt_q     <= '0;
      len_ovf_q <= 1'b0;
      last_q    <= 1'b0;
    end else if (cmd_i.acc) begin
      last_q <= last_i;
      if (cnt_full) begin
        len_ovf_q <= 1'b1;
      end else begin
        cross_q <= cross_q + CrossW'(pxy);
        rxx_q   <= rxx_q + EnergyW'(pxx[30:0]);
        ryy_q   <= ryy_q + EnergyW'(pyy[30:0]);
        cnt_q   <= cnt_next;
      end
    end else if (cmd_i.seg_emit) begin
      cross_q   <= '0;
      rxx_q     <= '0;
      ryy_q     <= '0;
      cnt_q     <= '0;
      len_ovf_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      segs_q     <= '0;
      total_q    <= '0;
      mean_ovf_q <= 1'b0;
    end else if (cmd_i.seg_emit) begin
      if (seg) begin
        if (res_status_q == ST_OVERFLOW ||
            (res_status_q != ST_SHORT && segs_q >= MaxSegments)) begin
          mean_ovf_q <= 1'b1;
        end else if (res_status_q != ST_SHORT) begin
          total_q <= total_q + TotalW'($signed(res_ratio_q));
          segs_q  <= segs_q + 1'b1;
        end
      end else if (last_q) begin
        segs_q     <= '0;
        total_q    <= '0;
        mean_ovf_q <= 1'b0;
      end
    end else if (cmd_i.mean_emit) begin
      segs_q     <= '0;
      total_q    <= '0;
      mean_ovf_q <= 1'b0;
    end
  end

  assign mag_full = cross_q[CrossW-1] ? CrossW'(-cross_q) : CrossW'(cross_q);
  assign mag      = mag_full[EnergyW-1:0];
  assign den      = ad_q - an_q;

  assign sq   = 64'(m_q) * 64'(m_q);
  assign ld   = {top_q, frac_q};
  assign dneg = ln_q < ld;
  assign dmag = dneg ? ld - ln_q : ln_q - ld;
  assign rsum = sc_q + (ScaleW'(1) << 39);
  assign rq   = rsum[ScaleW-1:40];

  assign mabs = total_q[TotalW-1] ? TotalW'(-total_q) : TotalW'(total_q);
  assign dv   = {segs_q, 1'b0};
  assign r2   = {rem_q, quo_q[TotalW-1]};
  assign ge   = r2 >= 19'(dv);

  always_ff @(posedge clk_i) begin
    if (cmd_i.set_special) begin
      priority if (len_ovf_q) begin
        res_ratio_q  <= '0;
        res_status_q <= ST_OVERFLOW;
      end else if (cnt_q < LenW'(2)) begin
        res_ratio_q  <= '0;
        res_status_q <= ST_SHORT;
      end else begin
        res_ratio_q  <= 16'h8000;
        res_status_q <= ST_ZERO_CORR;
      end
    end else if (cmd_i.set_full) begin
      res_ratio_q  <= 16'h7fff;
      res_status_q <= ST_ZERO_DIST;
    end else if (cmd_i.round) begin
      res_status_q <= ST_OK;
      if (neg_q) begin
        res_ratio_q <= (rq > 17'd32768) ? 16'h8000 : 16'(17'd0 - rq);
      end else begin
        res_ratio_q <= (rq > 17'd32767) ? 16'h7fff : rq[15:0];
      end
    end

    // shift-add multiply, MSB of the multiplier first
    if (cmd_i.mul_start) begin
      mag_q <= mag;
      bn_q  <= mag;
      bd_q  <= ryy_q;
      an_q  <= '0;
      ad_q  <= '0;
    end else if (cmd_i.mul_step) begin
      an_q <= {an_q[ProdW-2:0], 1'b0} + (bn_q[EnergyW-1] ? ProdW'(mag_q) : '0);
      ad_q <= {ad_q[ProdW-2:0], 1'b0} + (bd_q[EnergyW-1] ? ProdW'(rxx_q) : '0);
      bn_q <= {bn_q[EnergyW-2:0], 1'b0};
      bd_q <= {bd_q[EnergyW-2:0], 1'b0};
    end

    if (cmd_i.log_load) begin
      norm_q <= cmd_i.log_sel_den ? den : an_q;
      top_q  <= TopW'(ProdW - 1);
    end else if (cmd_i.norm_step) begin
      norm_q <= {norm_q[ProdW-2:0], 1'b0};
      top_q  <= top_q - 1'b1;
    end

    // one fraction bit per squaring of the mantissa
    if (cmd_i.log_mant) begin
      m_q    <= norm_q[ProdW-1:ProdW-32];
      frac_q <= '0;
    end else if (cmd_i.sqr_step) begin
      frac_q <= {frac_q[FracW-2:0], sq[63]};
      m_q    <= sq[63] ? sq[63:32] : sq[62:31];
    end

    if (cmd_i.store_ln) begin
      ln_q <= ld;
    end

    if (cmd_i.scale) begin
      neg_q <= dneg;
      sc_q  <= ScaleW'(dmag) * ScaleW'(DbPerOctave);
    end

    if (cmd_i.div_start) begin
      quo_q  <= {mabs[TotalW-2:0], 1'b0} + TotalW'(segs_q);
      rem_q  <= '0;
      mneg_q <= total_q[TotalW-1];
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? 18'(r2 - 19'(dv)) : r2[17:0];
      quo_q <= {quo_q[TotalW-2:0], ge};
    end
  end

  always_comb begin
    priority if (mean_ovf_q) begin
      mean_ratio  = '0;
      mean_status = ST_OVERFLOW;
    end else if (segs_q == '0) begin
      mean_ratio  = '0;
      mean_status = ST_SHORT;
    end else begin
      mean_ratio  = mneg_q ? 16'(-quo_q) : quo_q[15:0];
      mean_status = ST_OK;
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.seg_emit || cmd_i.mean_emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.seg_emit) begin
      out_kind_q   <= KindSeg;
      out_ratio_q  <= res_ratio_q;
      out_status_q <= res_status_q;
      out_last_q   <= !(last_q && seg);
    end else if (cmd_i.mean_emit) begin
      out_kind_q   <= KindMean;
      out_ratio_q  <= mean_ratio;
      out_status_q <= mean_status;
      out_last_q   <= 1'b1;
    end
  end

  always_comb begin
    stat_o.trigger      = last_i || (seg && cnt_next >= seg_len_i);
    stat_o.special      = len_ovf_q || (cnt_q < LenW'(2)) || (cross_q == '0);
    stat_o.den_zero     = den == '0;
    stat_o.norm_msb     = norm_q[ProdW-1];
    stat_o.out_free     = out_free;
    stat_o.mean_req     = last_q && seg;
    stat_o.mean_special = mean_ovf_q || (segs_q == '0);
  end

  assign out_valid_o  = out_valid_q;
  assign out_kind_o   = out_kind_q;
  assign out_last_o   = out_last_q;
  assign out_ratio_o  = out_ratio_q;
  assign out_status_o = out_status_q;

endmodule

// ----- hdl/ssdr_ctrl.sv -----
`timescale 1ns / 1ps
module ssdr_ctrl import ssdr_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_CHK   = 13'b0000000000010,
    S_MUL   = 13'b0000000000100,
    S_DZ    = 13'b0000000001000,
    S_NORM  = 13'b0000000010000,
    S_SQR   = 13'b0000000100000,
    S_LOADD = 13'b0000001000000,
    S_SCALE = 13'b0000010000000,
    S_ROUND = 13'b0000100000000,
    S_EMIT  = 13'b0001000000000,
    S_MCHK  = 13'b0010000000000,
    S_DIV   = 13'b0100000000000,
    S_MEMIT = 13'b1000000000000
  } state_e;

  state_e           state_q, state_d;
  logic [StepW-1:0] step_q, step_d;
  logic             den_q, den_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
      den_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      den_q   <= den_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    den_d      = den_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.acc = 1'b1;
          if (stat_i.trigger) state_d = S_CHK;
        end
      end
      S_CHK: begin
        if (stat_i.special) begin
          cmd_o.set_special = 1'b1;
          state_d = S_EMIT;
        end else begin
          cmd_o.mul_start = 1'b1;
          step_d  = '0;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul_step = 1'b1;
        step_d = step_q + 1'b1;
        if (step_q == MulLast) state_d = S_DZ;
      end
      S_DZ: begin
        if (stat_i.den_zero) begin
          cmd_o.set_full = 1'b1;
          state_d = S_EMIT;
        end else begin
          cmd_o.log_load = 1'b1;
          den_d   = 1'b0;
          state_d = S_NORM;
        end
      end
      S_NORM: begin
        if (stat_i.norm_msb) begin
          cmd_o.log_mant = 1'b1;
          step_d  = '0;
          state_d = S_SQR;
        end else begin
          cmd_o.norm_step = 1'b1;
        end
      end
      S_SQR: begin
        cmd_o.sqr_step = 1'b1;
        step_d = step_q + 1'b1;
        if (step_q == LogLast) state_d = den_q ? S_SCALE : S_LOADD;
      end
      S_LOADD: begin
        // keep the numerator log, start on the distortion term
        cmd_o.store_ln    = 1'b1;
        cmd_o.log_load    = 1'b1;
        cmd_o.log_sel_den = 1'b1;
        den_d   = 1'b1;
        state_d = S_NORM;
      end
      S_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d = S_ROUND;
      end
      S_ROUND: begin
        cmd_o.round = 1'b1;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.seg_emit = 1'b1;
          state_d = stat_i.mean_req ? S_MCHK : S_IDLE;
        end
      end
      S_MCHK: begin
        if (stat_i.mean_special) begin
          state_d = S_MEMIT;
        end else begin
          cmd_o.div_start = 1'b1;
          step_d  = '0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d = step_q + 1'b1;
        if (step_q == DivLast) state_d = S_MEMIT;
      end
      S_MEMIT: begin
        if (stat_i.out_free) begin
          cmd_o.mean_emit = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ----- verif/segmental_sdr_meter_tb.sv -----
`timescale 1ns / 1ps
module segmental_sdr_meter_tb;
  import ssdr_pkg::*;

  typedef enum int {OP_ITEM, OP_CFG, OP_SETTLE} req_op_e;

  typedef struct {
    req_op_e           op;
    logic signed [15:0] ref_s;
    logic signed [15:0] est_s;
    logic              last;
    logic [LenW-1:0]   seg_len;
  } sample_req_t;

  typedef struct {
    logic              kind;
    logic signed [15:0] ratio;
    status_e           status;
    logic              last;
  } sdr_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [31:0]         s_axis_tdata = '0;
  logic                s_axis_tlast = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [0:0]          m_axis_tuser;
  logic                m_axis_tlast;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [LenW-1:0]     cfg_data_i = '0;

  sample_req_t req_q[$];
  sdr_result_t sdr_q[$];
  int          err_cnt = 0;
  int          result_cnt = 0;
  int          item_cnt = 0;
  int          cfg_cnt = 0;
  int          cycle_cnt = 0;
  int          settle_cnt = 0;
  int          hold_cnt = 0;
  bit          hold_done = 1'b0;
  bit          stim_done = 1'b0;

  // predictor state
  int unsigned       pm_seg_len = 0;
  longint            pm_cross = 0;
  longint            pm_ref_e = 0;
  longint            pm_est_e = 0;
  int unsigned       pm_count = 0;
  int unsigned       pm_segs = 0;
  longint            pm_total = 0;
  bit                pm_len_ovf = 1'b0;
  bit                pm_mean_ovf = 1'b0;

  always #5 clk_i = ~clk_i;

  segmental_sdr_meter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // reference_sample, estimate_sample
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // ratio_db, status
    .m_axis_tuser  (m_axis_tuser),   // result_kind
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  function automatic longint unsigned log2_fixed(input bit [127:0] v);
    int                  top;
    bit [31:0]           m;
    bit [63:0]           sq;
    longint unsigned     r;
    top = -1;
    m = '0;
    for (int i = 127; i >= 0; i--) begin
      if (v[i] && top < 0) top = i;
    end
    if (top < 0) return 0;
    for (int k = 0; k < 32; k++) begin
      m = {m[30:0], (top - k >= 0) ? v[top-k] : 1'b0};
    end
    r = longint'(top) << FracW;
    for (int k = FracW - 1; k >= 0; k--) begin
      sq = {32'b0, m} * {32'b0, m};
      if (sq[63]) begin
        r[k] = 1'b1;
        m = sq[63:32];
      end else begin
        m = sq[62:31];
      end
    end
    return r;
  endfunction

  task automatic measure_sdr(output logic signed [15:0] ratio, output status_e st);
    bit [127:0]      mag, num, den;
    longint unsigned ln, ld, dmag, q;
    ratio = '0;
    if (pm_len_ovf) begin
      st = ST_OVERFLOW;
      return;
    end
    if (pm_count < 2) begin
      st = ST_SHORT;
      return;
    end
    mag = (pm_cross < 0) ? 128'(-pm_cross) : 128'(pm_cross);
    num = mag * mag;
    den = 128'(pm_ref_e) * 128'(pm_est_e) - num;
    if (num == 0) begin
      ratio = -16'sd32768;
      st = ST_ZERO_CORR;
      return;
    end
    if (den == 0) begin
      ratio = 16'sd32767;
      st = ST_ZERO_DIST;
      return;
    end
    st = ST_OK;
    ln = log2_fixed(num);
    ld = log2_fixed(den);
    dmag = (ln < ld) ? ld - ln : ln - ld;
    q = (dmag * 64'd50504453 + (64'd1 << 39)) >> 40;
    if (ln < ld) ratio = (q > 32768) ? -16'sd32768 : -16'(q);
    else ratio = (q > 32767) ? 16'sd32767 : 16'(q);
  endtask

  task automatic push_sdr(input logic kind, input logic signed [15:0] ratio,
                          input status_e st);
    sdr_result_t e;
    e.kind = kind;
    e.ratio = ratio;
    e.status = st;
    e.last = 1'b0;
    sdr_q.push_back(e);
  endtask

  task automatic predict_sample(input logic signed [15:0] x, input logic signed [15:0] y,
                                input logic last);
    bit                 seg;
    int                 n;
    logic signed [15:0] ratio;
    status_e            st;
    longint unsigned    m, q;
    seg = (pm_seg_len != 0);
    n = 0;
    if (pm_count >= (1 << 20)) begin
      pm_len_ovf = 1'b1;
    end else begin
      pm_cross += longint'(x) * longint'(y);
      pm_ref_e += longint'(x) * longint'(x);
      pm_est_e += longint'(y) * longint'(y);
      pm_count++;
    end
    if (last || (seg && pm_count >= pm_seg_len)) begin
      measure_sdr(ratio, st);
      push_sdr(KindSeg, ratio, st);
      n++;
      if (seg) begin
        if (st == ST_OVERFLOW || (st != ST_SHORT && pm_segs >= 65536)) begin
          pm_mean_ovf = 1'b1;
        end else if (st != ST_SHORT) begin
          pm_total += longint'(ratio);
          pm_segs++;
        end
      end
      pm_cross = 0;
      pm_ref_e = 0;
      pm_est_e = 0;
      pm_count = 0;
      pm_len_ovf = 1'b0;
    end
    if (seg && last) begin
      n++;
      if (pm_mean_ovf) begin
        push_sdr(KindMean, '0, ST_OVERFLOW);
      end else if (pm_segs == 0) begin
        push_sdr(KindMean, '0, ST_SHORT);
      end else begin
        m = (pm_total < 0) ? longint'(-pm_total) : longint'(pm_total);
        q = (2 * m + pm_segs) / (2 * longint'(pm_segs));
        push_sdr(KindMean, (pm_total < 0) ? -16'(q) : 16'(q), ST_OK);
      end
    end
    if (last) begin
      pm_segs = 0;
      pm_total = 0;
      pm_mean_ovf = 1'b0;
    end
    if (n > 0) sdr_q[$].last = 1'b1;
  endtask

  function automatic bit quiet_window();
    return cycle_cnt >= 3000 && cycle_cnt < 9000;
  endfunction

  // driver: requests come from req_q; writes and pauses wait until the block drains
  always @(posedge clk_i or negedge rst_ni) begin
    sample_req_t r;
    logic        nxt_valid, nxt_cfg;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      cfg_valid_i <= 1'b0;
      settle_cnt <= 0;
    end else begin
      cycle_cnt <= cycle_cnt + 1;
      if (s_axis_tvalid && s_axis_tready) begin
        predict_sample(s_axis_tdata[15:0], s_axis_tdata[31:16], s_axis_tlast);
        item_cnt++;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        pm_seg_len = 32'(cfg_data_i);
        cfg_cnt++;
      end
      nxt_valid = s_axis_tvalid && !s_axis_tready;
      nxt_cfg = cfg_valid_i && !cfg_ready_o;
      if (!nxt_valid && !nxt_cfg && req_q.size() > 0) begin
        r = req_q[0];
        if (r.op == OP_ITEM) begin
          if (quiet_window() || $urandom_range(99) >= 38) begin
            void'(req_q.pop_front());
            s_axis_tdata <= {r.est_s, r.ref_s};
            s_axis_tlast <= r.last;
            nxt_valid = 1'b1;
          end
        end else if (sdr_q.size() != 0 || s_axis_tvalid || cfg_valid_i) begin
          settle_cnt <= 0;
        end else if (settle_cnt < 16) begin
          settle_cnt <= settle_cnt + 1;
        end else begin
          settle_cnt <= 0;
          void'(req_q.pop_front());
          if (r.op == OP_CFG) begin
            cfg_data_i <= r.seg_len;
            nxt_cfg = 1'b1;
          end
        end
      end
      s_axis_tvalid <= nxt_valid;
      cfg_valid_i <= nxt_cfg;
    end
  end

  // monitor: check each result, stall the output at random and once for a long stretch
  always @(posedge clk_i or negedge rst_ni) begin
    sdr_result_t e;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        result_cnt++;
        if (sdr_q.size() == 0) begin
          $error("unexpected result: ratio_db %0d status %0d", $signed(m_axis_tdata[15:0]),
                 m_axis_tdata[18:16]);
          err_cnt++;
        end else begin
          e = sdr_q.pop_front();
          if (m_axis_tuser[0] !== e.kind) begin
            $error("result_kind expected %0d actual %0d", e.kind, m_axis_tuser[0]);
            err_cnt++;
          end
          if (m_axis_tdata[15:0] !== e.ratio) begin
            $error("ratio_db expected %0d actual %0d", e.ratio, $signed(m_axis_tdata[15:0]));
            err_cnt++;
          end
          if (m_axis_tdata[18:16] !== e.status) begin
            $error("status expected %0d actual %0d", e.status, m_axis_tdata[18:16]);
            err_cnt++;
          end
          if (m_axis_tlast !== e.last) begin
            $error("result_last expected %0d actual %0d", e.last, m_axis_tlast);
            err_cnt++;
          end
        end
      end
      if (!hold_done && result_cnt >= 60) begin
        hold_done <= 1'b1;
        hold_cnt <= 4000;
        m_axis_tready <= 1'b0;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= quiet_window() || $urandom_range(99) >= 38;
      end
    end
  end

  task automatic add_sample(input logic signed [15:0] x, input logic signed [15:0] y,
                            input logic last);
    sample_req_t r;
    r.op = OP_ITEM;
    r.ref_s = x;
    r.est_s = y;
    r.last = last;
    r.seg_len = '0;
    req_q.push_back(r);
  endtask

  task automatic add_ctrl(input req_op_e op, input int len);
    sample_req_t r;
    r.op = op;
    r.ref_s = '0;
    r.est_s = '0;
    r.last = 1'b0;
    r.seg_len = LenW'(len);
    req_q.push_back(r);
  endtask

  // mode 0 independent, 1 close estimate, 2 silent reference, 3 exact copy,
  // 4 inverted copy, 5 full-scale values
  task automatic add_stream(input int len, input int mode);
    logic signed [15:0] x, y;
    int                 sh;
    for (int i = 0; i < len; i++) begin
      x = 16'($urandom);
      if ($urandom_range(1)) x = x >>> $urandom_range(15);
      sh = $urandom_range(15);
      case (mode)
        0: y = 16'($urandom);
        1: y = x ^ 16'($urandom & ((1 << sh) - 1));
        2: begin
          x = '0;
          y = 16'($urandom);
        end
        3: y = x;
        4: y = -x;
        default: begin
          x = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
          y = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
        end
      endcase
      add_sample(x, y, i == len - 1);
    end
  endtask

  initial begin
    int               planned;
    int               len;
    planned = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: whole-stream cases first, then segmented ones
    add_ctrl(OP_CFG, 0);
    add_stream(1, 0);
    add_stream(3, 2);
    add_stream(3, 3);
    add_stream(2, 4);
    add_stream(3, 5);
    add_sample(16'sh7fff, 16'sh8000, 1'b0);
    add_sample(16'sh8000, 16'sh7fff, 1'b1);
    add_stream(3, 0);
    add_ctrl(OP_CFG, 1);
    add_stream(2, 1);
    add_ctrl(OP_CFG, 3);
    add_stream(7, 1);
    add_ctrl(OP_CFG, int'(MaxLength));
    add_stream(3, 1);
    planned = 29;

    while (planned < 1900) begin
      case ($urandom_range(5))
        0: len = 0;
        1: len = 1;
        2: len = 2;
        3: len = int'(MaxLength);
        default: len = $urandom_range(40, 3);
      endcase
      add_ctrl(OP_CFG, len);
      repeat ($urandom_range(4, 1)) begin
        int n;
        n = $urandom_range(60, 1);
        add_stream(n, ($urandom_range(9) < 6) ? 1 : $urandom_range(5));
        planned += n;
        if ($urandom_range(7) == 0) add_ctrl(OP_SETTLE, 0);
      end
    end
    add_ctrl(OP_SETTLE, 0);

    wait (req_q.size() == 0 && !s_axis_tvalid && !cfg_valid_i && sdr_q.size() == 0);
    repeat (500) @(posedge clk_i);
    if (sdr_q.size() != 0) begin
      $error("%0d expected results never arrived", sdr_q.size());
      err_cnt++;
    end
    $display("%0d sample pairs in %0d segment settings, %0d ratios checked",
             item_cnt, cfg_cnt, result_cnt);
    if (err_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ----- segmental_sdr_meter.f -----
hdl/ssdr_pkg.sv
hdl/ssdr_dp.sv
hdl/ssdr_ctrl.sv
hdl/segmental_sdr_meter.sv
verif/segmental_sdr_meter_tb.sv
